### rtl/core/mssw_pkg.sv
// ----------------------------------------------------------------------------
// mssw_pkg - shared definitions for the multi-slot square wave generator
// Command and transition codes, result type and arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mssw_pkg;

   // default slot count of the core
   localparam int SLOTS_DEFAULT = 8;

   // results reported per input item at most
   localparam int MAX_RESULTS = 8;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam int DUTY_FULL    = 100;
   localparam int PERIOD_FLOOR = 2;

   // floor(x / 100) == (x * RECIP_MUL) >> RECIP_SHIFT for x < 2**23
   localparam int          RECIP_SHIFT = 30;
   localparam logic [23:0] RECIP_MUL   = 24'd10737419;

   // command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   // transition codes
   localparam logic [1:0] TR_LOW    = 2'd0;
   localparam logic [1:0] TR_HIGH   = 2'd1;
   localparam logic [1:0] TR_TOGGLE = 2'd2;

   typedef struct packed {
      logic       last;
      logic [1:0] transition;
      logic [2:0] slot_res;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/core/multi_slot_square_wave_generator_core.sv
// ----------------------------------------------------------------------------
// multi_slot_square_wave_generator_core - multi-slot square wave generator
// Keeps SLOTS timed square-wave slots and reports their output transitions.
// ----------------------------------------------------------------------------
// Each request transfer carries a command in req_tuser. A start on an idle
// slot arms it (period 1 is raised to 2, a short nonzero duration is raised to
// the period, duty is clamped to 100 percent) and reports HIGH; a stop on an
// active slot disarms it and reports LOW; a tick walks all slots in order,
// counting down durations (LOW on expiry) and advancing phases (TOGGLE at
// phase 0 and at the toggle point period*duty/100). A tick reports at most
// eight transitions, the final one marked with rsp_tlast. The core handles one
// request at a time. A tick walks one slot per cycle through the single slot
// update unit, pausing while the result side stalls, then gives the final
// result; a start forms the toggle point in two steps on the shared
// multiplier, then arms the slot; a stop goes straight to the final step;
// an ignored request leaves the core idle. A start or stop also waits in its
// final step while the result register is still held by the result side. The
// result register lets the next request enter while the last result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_slot_square_wave_generator_core
   import mssw_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [2:0] slot, [18:3] run_length, [34:19] wave_period,
   // [41:35] duty_percent, [47:42] zero
   input  wire logic [47:0] req_tdata,
   // [1:0] command
   input  wire logic [1:0]  req_tuser,
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] slot_res, [4:3] transition, [7:5] zero
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);

   localparam int                SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL1  = 3'd1;
   localparam logic [2:0] ST_MUL2  = 3'd2;
   localparam logic [2:0] ST_START = 3'd3;
   localparam logic [2:0] ST_WALK  = 3'd4;
   localparam logic [2:0] ST_FLUSH = 3'd5;

   // request fields
   logic [1:0]  req_cmd;
   logic [2:0]  req_slot;
   logic [15:0] req_dur;
   logic [15:0] req_per;
   logic [6:0]  req_duty;

   assign req_cmd  = req_tuser;
   assign req_slot = req_tdata[2:0];
   assign req_dur  = req_tdata[18:3];
   assign req_per  = req_tdata[34:19];
   assign req_duty = req_tdata[41:35];

   // control state
   logic [2:0]        st_ff, st_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pend_vld_ff, pend_vld_in;
   logic              out_vld_ff, out_vld_in;
   logic [SLOTS-1:0]  active_ff, active_in;

   // payload
   rsp_type           pend_ff, pend_in;
   rsp_type           out_ff, out_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [15:0]       dur_ff, dur_in;
   logic [15:0]       per_ff, per_in;
   logic [6:0]        duty_ff, duty_in;
   logic [47:0]       prod_ff, prod_in;

   // per-slot tables
   logic [15:0] rem_ff   [SLOTS];
   logic [15:0] per_tab_ff [SLOTS];
   logic [15:0] tog_ff   [SLOTS];
   logic [15:0] ph_ff    [SLOTS];

   // request decode
   logic [SLOT_W-1:0] req_idx;
   logic              slot_ok;
   logic [15:0]       per_raised;
   logic [15:0]       dur_raised;
   logic [6:0]        duty_sat;

   assign req_idx    = SLOT_W'(req_slot);
   assign slot_ok    = 6'(req_slot) < 6'(SLOTS);
   assign per_raised = (req_per == 16'd1) ? 16'(PERIOD_FLOOR) : req_per;
   assign dur_raised = ((req_dur != 16'd0) && (req_dur < per_raised)) ? per_raised : req_dur;
   assign duty_sat   = (req_duty > 7'(DUTY_FULL)) ? 7'(DUTY_FULL) : req_duty;

   // shared multiplier: period*duty, then the reciprocal step for /100
   logic [23:0] mul_a, mul_b;
   logic [47:0] mul_p;

   always_comb begin
      if (st_ff == ST_MUL2) begin
         mul_a = {1'b0, prod_ff[22:0]};
         mul_b = RECIP_MUL;
      end else begin
         mul_a = {8'd0, per_ff};
         mul_b = {17'd0, duty_ff};
      end
   end

   assign mul_p = mul_a * mul_b;

   // slot update unit, works on the slot under the walk index
   logic        w_act;
   logic [15:0] w_rem, w_per, w_tog, w_ph;
   logic        w_expire;
   logic [16:0] w_ph_inc;
   logic [15:0] w_ph_new;
   logic        w_hit;
   logic        w_ev;
   logic [1:0]  w_tr;
   logic        w_keep;
   logic        out_free;
   logic        w_stall;

   assign w_act    = active_ff[idx_ff];
   assign w_rem    = rem_ff[idx_ff];
   assign w_per    = per_tab_ff[idx_ff];
   assign w_tog    = tog_ff[idx_ff];
   assign w_ph     = ph_ff[idx_ff];
   assign w_expire = (w_rem == 16'd1);
   assign w_ph_inc = {1'b0, w_ph} + 17'd1;
   assign w_ph_new = (w_ph_inc == {1'b0, w_per}) ? 16'd0 : w_ph_inc[15:0];
   assign w_hit    = (w_ph_new == 16'd0) || (w_ph_new == w_tog);
   assign w_ev     = w_act && (w_expire || ((w_per != 16'd0) && w_hit));
   assign w_tr     = w_expire ? TR_LOW : TR_TOGGLE;
   assign w_keep   = w_ev && (cnt_ff < CNT_W'(MAX_RESULTS));
   assign out_free = !out_vld_ff || rsp_tready;
   // a new result must displace the pending one, which needs a free output
   assign w_stall  = w_keep && pend_vld_ff && !out_free;

   logic start_wr;
   logic walk_wr;

   always_comb begin
      st_in       = st_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_in      = out_ff;
      active_in   = active_ff;
      slot_in     = slot_ff;
      dur_in      = dur_ff;
      per_in      = per_ff;
      duty_in     = duty_ff;
      prod_in     = prod_ff;
      start_wr    = 1'b0;
      walk_wr     = 1'b0;

      unique case (st_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               slot_in = req_idx;
               dur_in  = dur_raised;
               per_in  = per_raised;
               duty_in = duty_sat;
               unique case (req_cmd)
                  CMD_TICK: begin
                     idx_in = '0;
                     cnt_in = '0;
                     st_in  = ST_WALK;
                  end
                  CMD_START: begin
                     if (slot_ok && !active_ff[req_idx]) begin
                        st_in = ST_MUL1;
                     end
                  end
                  CMD_STOP: begin
                     if (slot_ok && active_ff[req_idx]) begin
                        // drop the active mark, report LOW
                        active_in[req_idx] = 1'b0;
                        pend_in.last       = 1'b0;
                        pend_in.transition = TR_LOW;
                        pend_in.slot_res   = req_slot;
                        pend_vld_in        = 1'b1;
                        st_in              = ST_FLUSH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL1: begin
            prod_in = mul_p;
            st_in   = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in = mul_p;
            st_in   = ST_START;
         end
         ST_START: begin
            start_wr           = 1'b1;
            active_in[slot_ff] = 1'b1;
            pend_in.last       = 1'b0;
            pend_in.transition = TR_HIGH;
            pend_in.slot_res   = 3'(slot_ff);
            pend_vld_in        = 1'b1;
            st_in              = ST_FLUSH;
         end
         ST_WALK: begin
            if (!w_stall) begin
               walk_wr = w_act;
               if (w_act && w_expire) begin
                  active_in[idx_ff] = 1'b0;
               end
               if (w_keep) begin
                  // hand the previous result on, hold the new one back
                  if (pend_vld_ff) begin
                     out_vld_in = 1'b1;
                     out_in     = pend_ff;
                  end
                  pend_in.last       = 1'b0;
                  pend_in.transition = w_tr;
                  pend_in.slot_res   = 3'(idx_ff);
                  pend_vld_in        = 1'b1;
                  cnt_in             = cnt_ff + CNT_W'(1);
               end
               if (idx_ff == LAST_IDX) begin
                  st_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + SLOT_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff) begin
               st_in = ST_IDLE;
            end else if (out_free) begin
               // final result of this request
               out_vld_in   = 1'b1;
               out_in       = pend_ff;
               out_in.last  = 1'b1;
               pend_vld_in  = 1'b0;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         idx_ff      <= '0;
         cnt_ff      <= '0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         active_ff   <= '0;
      end else begin
         st_ff       <= st_in;
         idx_ff      <= idx_in;
         cnt_ff      <= cnt_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
         active_ff   <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
      slot_ff <= slot_in;
      dur_ff  <= dur_in;
      per_ff  <= per_in;
      duty_ff <= duty_in;
      prod_ff <= prod_in;
   end

   // slot tables, written by a start or by the walk
   always_ff @(posedge clock) begin
      if (start_wr) begin
         rem_ff[slot_ff]     <= dur_ff;
         per_tab_ff[slot_ff] <= per_ff;
         tog_ff[slot_ff]     <= prod_ff[RECIP_SHIFT+15:RECIP_SHIFT];
         ph_ff[slot_ff]      <= 16'd0;
      end else if (walk_wr) begin
         if (w_rem != 16'd0) begin
            rem_ff[idx_ff] <= w_rem - 16'd1;
         end
         if (!w_expire && (w_per != 16'd0)) begin
            ph_ff[idx_ff] <= w_ph_new;
         end
      end
   end

   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'd0, out_ff.transition, out_ff.slot_res};
   assign rsp_tlast  = out_ff.last;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("result count above limit");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_IDLE) |-> !pend_vld_ff)
      else $error("pending result left behind in idle");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_WALK) |-> (32'(idx_ff) < SLOTS))
      else $error("walk index out of range");

   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_START) |=> active_ff[slot_ff])
      else $error("start did not arm the slot");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      ((st_ff == ST_WALK) && w_act && (w_per != 16'd0)) |-> (w_ph < w_per))
      else $error("phase not below period");

endmodule

`default_nettype wire
